/* sv/tlcs_pkg.sv */
`default_nettype none
package tlcs_pkg;

  localparam int NUM_LINES = 256;
  localparam int LINE_AW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  localparam logic [2:0] OP_PICKUP   = 3'd0;
  localparam logic [2:0] OP_HANGUP   = 3'd1;
  localparam logic [2:0] OP_DIAL     = 3'd2;
  localparam logic [2:0] OP_CHAT     = 3'd3;
  localparam logic [2:0] OP_ANNOUNCE = 3'd4;

  localparam logic [2:0] ST_ON_HOOK   = 3'd0;
  localparam logic [2:0] ST_RINGING   = 3'd1;
  localparam logic [2:0] ST_DIAL_TONE = 3'd2;
  localparam logic [2:0] ST_RING_BACK = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_CONNECTED = 3'd5;
  localparam logic [2:0] ST_ERROR     = 3'd6;

  localparam logic KIND_STATE = 1'b0;
  localparam logic KIND_CHAT  = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] line;
    logic [7:0] target_line;
    logic       target_present;
  } in_item_t;

  typedef struct packed {
    logic [7:0] dest_line;
    logic       kind;
    logic [2:0] line_state;
    logic [7:0] shown_line;
    logic       shows_line;
    logic       status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] state;
    logic [7:0] peer;
    logic       pv;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic load_a;
    logic exec;
    logic we_a;
    logic we_b;
    logic sel_peer;
  } cmd_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic peer_item;
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_EXEC,
    S_WR_A,
    S_WR_B,
    S_OUT_PEER,
    S_OUT_OWN
  } fsm_t;

endpackage
`default_nettype wire

/* sv/tlcs_ctrl.sv */
`default_nettype none
module tlcs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ev_valid,
  output logic               ev_ready,
  output logic               note_valid,
  input  wire logic          note_ready,
  input  wire tlcs_pkg::sts_t sts,
  output tlcs_pkg::cmd_t     cmd
);
  import tlcs_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ev_ready   = 1'b0;
    note_valid = 1'b0;
    case (state)
      S_IDLE: begin
        ev_ready = 1'b1;
        if (ev_valid) begin
          cmd.accept = 1'b1;
          state_next = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd.load_a = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_WR_A;
      end
      S_WR_A: begin
        cmd.we_a   = sts.wr_a;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.we_b   = sts.wr_b;
        state_next = sts.peer_item ? S_OUT_PEER : S_OUT_OWN;
      end
      S_OUT_PEER: begin
        note_valid   = 1'b1;
        cmd.sel_peer = 1'b1;
        if (note_ready) begin
          state_next = S_OUT_OWN;
        end
      end
      S_OUT_OWN: begin
        note_valid = 1'b1;
        if (note_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_ready |=> !ev_ready)
    else $error("item accepted while another is in flight");

  a_peer_sel: assert property (@(posedge clk) disable iff (rst)
    cmd.sel_peer |-> sts.peer_item)
    else $error("peer item shown without one pending");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    note_valid && note_ready && !cmd.sel_peer |=> ev_ready)
    else $error("not ready after final item");
`endif

endmodule
`default_nettype wire

/* sv/tlcs_dp.sv */
`default_nettype none
module tlcs_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlcs_pkg::cmd_t     cmd,
  input  wire tlcs_pkg::in_item_t ev,
  output tlcs_pkg::sts_t          sts,
  output tlcs_pkg::out_item_t     note
);
  import tlcs_pkg::*;

  entry_t               mem [NUM_LINES];
  logic [NUM_LINES-1:0] written;
  entry_t               rdata;
  logic                 rvalid;
  entry_t               rd_ent;
  logic [LINE_AW-1:0]   raddr;
  logic [LINE_AW-1:0]   waddr;
  entry_t               wdata;
  logic                 we;

  in_item_t   ev_q;
  entry_t     a_q;
  logic [7:0] b_line_q;
  entry_t     na_q, nb_q;
  logic       wr_a_q, wr_b_q, peer_item_q, chat_q, status_q, line_bad_q;

  entry_t     na, nb;
  logic       wr_a, wr_b, peer_item, chat, status, line_bad, pv, tg_bad;
  logic [7:0] b_sel;

  function automatic out_item_t notify(entry_t e, logic [7:0] ln, logic st, logic lst);
    out_item_t o;
    o.dest_line  = ln;
    o.kind       = KIND_STATE;
    o.line_state = e.state;
    o.shown_line = 8'd0;
    o.shows_line = 1'b0;
    o.status     = lst ? st : 1'b0;
    o.last       = lst;
    if (e.state == ST_ON_HOOK) begin
      o.shown_line = ln;
      o.shows_line = 1'b1;
    end else if (e.state == ST_CONNECTED && e.pv) begin
      o.shown_line = e.peer;
      o.shows_line = 1'b1;
    end
    return o;
  endfunction

  assign rd_ent = rvalid ? rdata : entry_t'('0);
  assign b_sel  = (ev_q.opcode == OP_DIAL) ? ev_q.target_line : rd_ent.peer;
  assign raddr  = cmd.accept ? LINE_AW'(ev.line) : LINE_AW'(b_sel);
  assign we     = cmd.we_a || cmd.we_b;
  assign waddr  = cmd.we_b ? LINE_AW'(b_line_q) : LINE_AW'(ev_q.line);
  assign wdata  = cmd.we_b ? nb_q : na_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rvalid <= written[raddr];
    end
  end

  always_comb begin
    na        = a_q;
    nb        = rd_ent;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    peer_item = 1'b0;
    chat      = 1'b0;
    status    = 1'b0;
    line_bad  = 32'(ev_q.line) >= NUM_LINES;
    tg_bad    = 32'(ev_q.target_line) >= NUM_LINES;
    pv        = a_q.pv && (32'(a_q.peer) < NUM_LINES);
    if (!line_bad) begin
      case (ev_q.opcode)
        OP_PICKUP: begin
          if (a_q.state == ST_ON_HOOK) begin
            na.state = ST_DIAL_TONE;
            wr_a     = 1'b1;
          end else if (a_q.state == ST_RINGING) begin
            if (pv) begin
              na.state  = ST_CONNECTED;
              nb.state  = ST_CONNECTED;
              wr_a      = 1'b1;
              wr_b      = 1'b1;
              peer_item = 1'b1;
            end else begin
              status = 1'b1;
            end
          end
        end
        OP_HANGUP: begin
          if (a_q.state inside {ST_CONNECTED, ST_RINGING, ST_RING_BACK}) begin
            na.state = ST_ON_HOOK;
            if (pv) begin
              nb.state  = (a_q.state == ST_RING_BACK) ? ST_ON_HOOK : ST_DIAL_TONE;
              nb.pv     = 1'b0;
              nb.peer   = 8'd0;
              wr_b      = 1'b1;
              peer_item = 1'b1;
            end else begin
              status = 1'b1;
            end
          end else if (a_q.state inside {ST_DIAL_TONE, ST_BUSY, ST_ERROR}) begin
            na.state = ST_ON_HOOK;
          end
          na.pv   = 1'b0;
          na.peer = 8'd0;
          wr_a    = 1'b1;
        end
        OP_DIAL: begin
          if (a_q.state == ST_DIAL_TONE) begin
            wr_a = 1'b1;
            if (ev_q.target_present && ev_q.target_line == ev_q.line) begin
              na.state = ST_BUSY;
            end else if (!ev_q.target_present || tg_bad) begin
              na.state = ST_ERROR;
              status   = 1'b1;
            end else if (rd_ent.pv || rd_ent.state != ST_ON_HOOK) begin
              na.state = ST_BUSY;
            end else begin
              na.state  = ST_RING_BACK;
              na.peer   = ev_q.target_line;
              na.pv     = 1'b1;
              nb.state  = ST_RINGING;
              nb.peer   = ev_q.line;
              nb.pv     = 1'b1;
              wr_b      = 1'b1;
              peer_item = 1'b1;
            end
          end
        end
        OP_CHAT: begin
          if (a_q.state == ST_CONNECTED && pv) begin
            peer_item = 1'b1;
            chat      = 1'b1;
          end else begin
            status = 1'b1;
          end
        end
        OP_ANNOUNCE: begin
        end
        default: begin
          status = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ev_q <= ev;
    end
    if (cmd.load_a) begin
      a_q      <= rd_ent;
      b_line_q <= b_sel;
    end
    if (cmd.exec) begin
      na_q        <= na;
      nb_q        <= nb;
      chat_q      <= chat;
      status_q    <= status;
      line_bad_q  <= line_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_a_q      <= 1'b0;
      wr_b_q      <= 1'b0;
      peer_item_q <= 1'b0;
    end else if (cmd.exec) begin
      wr_a_q      <= wr_a;
      wr_b_q      <= wr_b;
      peer_item_q <= peer_item;
    end
  end

  assign sts.wr_a      = wr_a_q;
  assign sts.wr_b      = wr_b_q;
  assign sts.peer_item = peer_item_q;

  always_comb begin
    if (cmd.sel_peer) begin
      if (chat_q) begin
        note.dest_line  = b_line_q;
        note.kind       = KIND_CHAT;
        note.line_state = ST_ON_HOOK;
        note.shown_line = ev_q.line;
        note.shows_line = 1'b1;
        note.status     = 1'b0;
        note.last       = 1'b0;
      end else begin
        note = notify(nb_q, b_line_q, 1'b0, 1'b0);
      end
    end else if (line_bad_q) begin
      note.dest_line  = ev_q.line;
      note.kind       = KIND_STATE;
      note.line_state = ST_ERROR;
      note.shown_line = 8'd0;
      note.shows_line = 1'b0;
      note.status     = 1'b1;
      note.last       = 1'b1;
    end else begin
      note = notify(na_q, ev_q.line, status_q, 1'b1);
    end
  end

endmodule
`default_nettype wire

/* sv/telephone_line_call_state_core.sv */
// First result item is presented after states S_RD_B, S_EXEC, S_WR_A and S_WR_B.
// One event at a time: the next waits until the last result item is taken.
// The fixed controller sequence is two table reads, one update, two table writes.
// Reset: synchronous, active high; every line reads on hook with no peer at once,
// through per-line written bits, with no clearing pass.
`default_nettype none
module telephone_line_call_state_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ev_valid,
  output logic                     ev_ready,
  input  wire tlcs_pkg::in_item_t  ev,
  output logic                     note_valid,
  input  wire logic                note_ready,
  output tlcs_pkg::out_item_t      note
);
  import tlcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlcs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .note_valid (note_valid),
    .note_ready (note_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlcs_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ev   (ev),
    .sts  (sts),
    .note (note)
  );

endmodule
`default_nettype wire
